### rtl/core/strint_pkg.sv
// Shared types, constants and the character classifier of the string-to-integer parser.
package strint_pkg;

	// Consumed count saturates here.
	localparam logic [11:0] COUNT_CAP = 12'd4095;

	// Bases picked by prefix detection.
	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;

	// Queue between the front and back parts holds two items.
	localparam logic [1:0] QUEUE_FULL  = 2'd2;
	localparam logic [1:0] QUEUE_EMPTY = 2'd0;

	// Character codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	// Offsets that turn a letter into its digit value (letter - 'a' + 10, or letter - 'A' + 10).
	localparam logic [7:0] LO_OFFSET = 8'd87;
	localparam logic [7:0] UP_OFFSET = 8'd55;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_PFX,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	// One classified character as it travels through the queue.
	typedef struct packed {
		logic       start;
		logic       ws;
		logic       minus;
		logic       plus;
		logic       zero;
		logic       xchar;
		logic       alnum;
		logic [5:0] digit;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c, input logic st);
		char_class_t r;
		logic is_num;
		logic is_lo;
		logic is_up;
		is_num  = (c >= CH_DIG0) && (c <= CH_DIG9);
		is_lo   = (c >= CH_LO_A) && (c <= CH_LO_Z);
		is_up   = (c >= CH_UP_A) && (c <= CH_UP_Z);
		r.start = st;
		r.ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
		r.minus = (c == CH_MINUS);
		r.plus  = (c == CH_PLUS);
		r.zero  = (c == CH_DIG0);
		r.xchar = (c == CH_LO_X) || (c == CH_UP_X);
		r.alnum = is_num || is_lo || is_up;
		if (is_num) begin
			r.digit = 6'(c - CH_DIG0);
		end else if (is_lo) begin
			r.digit = 6'(c - LO_OFFSET);
		end else if (is_up) begin
			r.digit = 6'(c - UP_OFFSET);
		end else begin
			r.digit = 6'd0;
		end
		return r;
	endfunction

endpackage

### rtl/core/string_to_integer_parser_unit.sv
// Top level of the string-to-integer parser: front, queue and back part.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  char     | char_valid/char_stall  | ch[7:0], start_req
//  result   | res_valid/res_stall    | value[63:0] signed, consumed[11:0]
//  config   | cfg_wr_en              | cfg_wr_data[5:0] (radix)
//
// One character per cycle sustained without res_stall; the back stage's
// 64-by-6 multiply-add sets that figure. A result is registered as its stop
// character leaves the queue. char_stall rises only when the two-entry queue
// is full; a stalled result does not block the queue until the next result.
// arst_n clears the parse state, the queue and radix (to automatic base).
module string_to_integer_parser_unit
	import strint_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [5:0]         cfg_wr_data,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         ch,
	input  logic               start_req,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [63:0] value,
	output logic [11:0]        consumed
);

	logic        q_push;
	logic        q_pop;
	logic [1:0]  q_level;
	char_class_t q_wdata;
	char_class_t q_rdata;
	logic [63:0] value_raw;

	strint_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ch         (ch),
		.start_req  (start_req),
		.q_level    (q_level),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	strint_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.level  (q_level)
	);

	strint_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_level     (q_level),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.value       (value_raw),
		.consumed    (consumed)
	);

	assign value = signed'(value_raw);

	// A new result only comes from an item popped the cycle before.
	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(q_pop))
		else $error("result raised without a popped item");

	// Never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_level == QUEUE_FULL) |-> !q_push)
		else $error("push into full queue");

	// Fill level follows push without pop.
	a_level_up: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_level == $past(q_level) + 2'd1))
		else $error("queue level did not advance");

	// Never pop an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_level == QUEUE_EMPTY) |-> !q_pop)
		else $error("pop from empty queue");

endmodule

### rtl/core/strint_front.sv
// Front part: accepts characters, classifies them and pushes them into the queue.
module strint_front
	import strint_pkg::*;
(
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  ch,
	input  logic        start_req,
	input  logic [1:0]  q_level,
	output logic        q_push,
	output char_class_t q_wdata
);

	// Stall while the queue has no free slot.
	assign char_stall = (q_level == QUEUE_FULL);

	// Push every accepted item.
	assign q_push  = char_valid && !char_stall;
	assign q_wdata = classify(ch, start_req);

endmodule

### rtl/core/strint_fifo.sv
// Two-entry queue of classified characters between the front and back parts.
module strint_fifo
	import strint_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_class_t wdata,
	input  logic        pop,
	output char_class_t rdata,
	output logic [1:0]  level
);

	char_class_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  level_q;

	// Advance pointers and track fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= QUEUE_EMPTY;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	// Store the pushed item.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign level = level_q;

endmodule

### rtl/core/strint_back.sv
// Back part: parse state machine, multiply-add accumulator and result register.
module strint_back
	import strint_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [5:0]   cfg_wr_data,
	input  logic [1:0]   q_level,
	input  char_class_t  q_rdata,
	output logic         q_pop,
	output logic         res_valid,
	input  logic         res_stall,
	output logic [63:0]  value,
	output logic [11:0]  consumed
);

	logic [5:0]  radix_q;
	phase_t      phase_q;
	phase_t      phase_d;
	phase_t      phase_eff;
	logic        neg_q;
	logic [63:0] acc_q;
	logic [11:0] cnt_q;
	logic [5:0]  base_q;
	logic        res_valid_q;
	logic [63:0] value_q;
	logic [11:0] consumed_q;

	logic        neg_eff;
	logic [63:0] acc_eff;
	logic [11:0] cnt_eff;
	logic [5:0]  base_eff;
	logic        out_free;
	logic        pfx_zero;
	logic [5:0]  digit_base;
	logic        digit_ok;
	logic [63:0] mac;
	logic        take_pfx;
	logic        take_digit;
	logic        emit;
	logic        neg_set;
	logic        x_prefix;

	// Pop when the result register can take whatever this item causes.
	assign out_free = !res_valid_q || !res_stall;
	assign q_pop    = (q_level != QUEUE_EMPTY) && (out_free || !emit);

	// A start character restarts the parse from a clean state.
	assign phase_eff = q_rdata.start ? PH_LEAD : phase_q;
	assign neg_eff   = q_rdata.start ? 1'b0 : neg_q;
	assign acc_eff   = q_rdata.start ? 64'd0 : acc_q;
	assign cnt_eff   = q_rdata.start ? 12'd0 : cnt_q;
	assign base_eff  = q_rdata.start ? 6'd0 : base_q;

	assign pfx_zero = ((radix_q == BASE_AUTO) || (radix_q == BASE_HEX)) && q_rdata.zero;

	// Pick the base this character is judged against.
	always_comb begin
		case (phase_eff)
			PH_LEAD, PH_PFX: digit_base = (radix_q == BASE_AUTO) ? BASE_DEC : radix_q;
			PH_ZERO:         digit_base = (radix_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			default:         digit_base = base_eff;
		endcase
	end

	assign digit_ok = q_rdata.alnum && (q_rdata.digit < digit_base);
	assign mac      = 64'(acc_eff * 64'(digit_base)) + 64'(q_rdata.digit);

	// Next state.
	always_comb begin
		case (phase_eff)
			PH_LEAD: begin
				if (q_rdata.ws) begin
					phase_d = PH_LEAD;
				end else if (q_rdata.minus || q_rdata.plus) begin
					phase_d = PH_PFX;
				end else if (pfx_zero) begin
					phase_d = PH_ZERO;
				end else begin
					phase_d = digit_ok ? PH_DIGITS : PH_IDLE;
				end
			end
			PH_PFX: begin
				if (pfx_zero) begin
					phase_d = PH_ZERO;
				end else begin
					phase_d = digit_ok ? PH_DIGITS : PH_IDLE;
				end
			end
			PH_ZERO: begin
				if (q_rdata.xchar || digit_ok) begin
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DIGITS: phase_d = digit_ok ? PH_DIGITS : PH_IDLE;
			default:   phase_d = PH_IDLE;
		endcase
	end

	// Actions taken on the current character.
	always_comb begin
		take_pfx   = 1'b0;
		take_digit = 1'b0;
		emit       = 1'b0;
		neg_set    = 1'b0;
		x_prefix   = 1'b0;
		case (phase_eff)
			PH_LEAD: begin
				if (q_rdata.ws || q_rdata.plus) begin
					take_pfx = 1'b1;
				end else if (q_rdata.minus) begin
					take_pfx = 1'b1;
					neg_set  = 1'b1;
				end else if (pfx_zero) begin
					take_pfx = 1'b1;
				end else begin
					take_digit = digit_ok;
					emit       = !digit_ok;
				end
			end
			PH_PFX: begin
				if (pfx_zero) begin
					take_pfx = 1'b1;
				end else begin
					take_digit = digit_ok;
					emit       = !digit_ok;
				end
			end
			PH_ZERO: begin
				if (q_rdata.xchar) begin
					take_pfx = 1'b1;
					x_prefix = 1'b1;
				end else begin
					take_digit = digit_ok;
					emit       = !digit_ok;
				end
			end
			PH_DIGITS: begin
				take_digit = digit_ok;
				emit       = !digit_ok;
			end
			default: begin
				take_pfx = 1'b0;
			end
		endcase
	end

	// Control state: radix, phase, sign, count, base, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= BASE_AUTO;
			phase_q     <= PH_IDLE;
			neg_q       <= 1'b0;
			cnt_q       <= 12'd0;
			base_q      <= 6'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
			if (q_pop) begin
				phase_q <= phase_d;
				neg_q   <= neg_eff || neg_set;
				if ((take_pfx || take_digit) && (cnt_eff != COUNT_CAP)) begin
					cnt_q <= cnt_eff + 12'd1;
				end else begin
					cnt_q <= cnt_eff;
				end
				// Fix the base when digits begin.
				if (phase_eff != PH_DIGITS) begin
					base_q <= x_prefix ? BASE_HEX : digit_base;
				end else begin
					base_q <= base_eff;
				end
			end
			if (out_free) begin
				res_valid_q <= q_pop && emit;
			end
		end
	end

	// Accumulator and result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_q <= take_digit ? mac : acc_eff;
		end
		if (q_pop && emit) begin
			value_q    <= neg_eff ? (64'd0 - acc_eff) : acc_eff;
			consumed_q <= cnt_eff;
		end
	end

	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign consumed  = consumed_q;

endmodule

### test/testbench.sv
// Self-checking testbench for the string-to-integer parser: predicts each parse and compares.
`timescale 1ns / 100ps

module testbench;
	import strint_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [6:0] NOT_DIGIT = 7'd64;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [63:0] value;
		logic [11:0] consumed;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = '0;
	logic char_valid = 1'b0;
	logic char_stall;
	logic [7:0] ch = '0;
	logic start_req = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [63:0] value;
	logic [11:0] consumed;

	// Parser state as the block should hold it
	phase_t pr_phase = PH_IDLE;
	logic pr_negative = 1'b0;
	logic [63:0] pr_accum = '0;
	logic [11:0] pr_count = '0;
	logic [5:0] pr_base = '0;
	logic [5:0] radix_now = BASE_AUTO;

	parse_result_t results_due[$];
	logic [7:0] char_buf[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;
	int unsigned idle_run = 0;
	int fail_count = 0;

	string_to_integer_parser_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.ch(ch),
		.start_req(start_req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value(value),
		.consumed(consumed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [11:0] count_up(input logic [11:0] n);
		return (n < COUNT_CAP) ? n + 12'd1 : n;
	endfunction

	function automatic logic [6:0] digit_value(input logic [7:0] c);
		if (c >= CH_DIG0 && c <= CH_DIG9) return 7'(c - CH_DIG0);
		if (c >= CH_LO_A && c <= CH_LO_Z) return 7'(c - CH_LO_A) + 7'd10;
		if (c >= CH_UP_A && c <= CH_UP_Z) return 7'(c - CH_UP_A) + 7'd10;
		return NOT_DIGIT;
	endfunction

	// Advance the parser by one accepted item; queue the result on a stop
	function automatic void advance_parser(input logic [7:0] c, input logic st);
		logic [6:0] d;
		parse_result_t res;
		if (st) begin
			pr_phase = PH_LEAD;
			pr_negative = 1'b0;
			pr_accum = '0;
			pr_count = '0;
			pr_base = '0;
		end
		if (pr_phase == PH_IDLE) return;
		if (pr_phase == PH_LEAD) begin
			if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
				pr_count = count_up(pr_count);
				return;
			end
			pr_phase = PH_PFX;
			if (c == CH_MINUS || c == CH_PLUS) begin
				pr_negative = (c == CH_MINUS);
				pr_count = count_up(pr_count);
				return;
			end
		end
		if (pr_phase == PH_PFX) begin
			if ((radix_now == BASE_AUTO || radix_now == BASE_HEX) && c == CH_DIG0) begin
				pr_count = count_up(pr_count);
				pr_phase = PH_ZERO;
				return;
			end
			pr_base = (radix_now == BASE_AUTO) ? BASE_DEC : radix_now;
			pr_phase = PH_DIGITS;
		end else if (pr_phase == PH_ZERO) begin
			if (c == CH_LO_X || c == CH_UP_X) begin
				pr_count = count_up(pr_count);
				pr_base = BASE_HEX;
				pr_phase = PH_DIGITS;
				return;
			end
			pr_base = (radix_now == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			pr_phase = PH_DIGITS;
		end
		// Take a digit below the base, otherwise stop
		d = digit_value(c);
		if (d < 7'(pr_base)) begin
			pr_accum = pr_accum * 64'(pr_base) + 64'(d);
			pr_count = count_up(pr_count);
			return;
		end
		res.value = pr_negative ? -pr_accum : pr_accum;
		res.consumed = pr_count;
		results_due.push_back(res);
		pr_phase = PH_IDLE;
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) return CH_DIG0 + 8'(d);
		if ($urandom_range(1)) return CH_LO_A + 8'(d - 10);
		return CH_UP_A + 8'(d - 10);
	endfunction

	// Offer one item after a random gap; predict once it is accepted
	task automatic send_char(input logic [7:0] c, input logic st);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		ch <= c;
		start_req <= st;
		do @(posedge clk); while (char_stall);
		advance_parser(c, st);
		@(negedge clk);
	endtask

	task automatic send_buf();
		foreach (char_buf[i]) send_char(char_buf[i], i == 0);
	endtask

	task automatic send_text(input string s, input bit terminate);
		char_buf.delete();
		for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
		if (terminate) char_buf.push_back(CH_NUL);
		send_buf();
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Close any open string, drain, then write the radix
	task automatic write_radix(input logic [5:0] r);
		if (pr_phase != PH_IDLE) send_char(CH_NUL, 1'b0);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		radix_now = r;
	endtask

	task automatic set_idling(input int unsigned snd, input int unsigned rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
	endtask

	// Fill char_buf with one plausible string for the current radix
	task automatic build_random_string();
		int unsigned n_lead;
		int unsigned n_dig;
		int unsigned b;
		char_buf.delete();
		n_lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n_lead) begin
			case ($urandom_range(2))
				0: char_buf.push_back(CH_SPACE);
				1: char_buf.push_back(CH_TAB);
				default: char_buf.push_back(CH_LF);
			endcase
		end
		case ($urandom_range(3))
			0: char_buf.push_back(CH_MINUS);
			1: char_buf.push_back(CH_PLUS);
			default: ;
		endcase
		b = 32'((radix_now == BASE_AUTO) ? BASE_DEC : radix_now);
		if (radix_now == BASE_AUTO || radix_now == BASE_HEX) begin
			case ($urandom_range(3))
				0: begin
					char_buf.push_back(CH_DIG0);
					char_buf.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
					b = 32'(BASE_HEX);
				end
				1: begin
					char_buf.push_back(CH_DIG0);
					if (radix_now == BASE_AUTO) b = 32'(BASE_OCT);
				end
				default: ;
			endcase
		end
		n_dig = ($urandom_range(7) == 0) ? $urandom_range(15, 28) : $urandom_range(0, 8);
		repeat (n_dig) char_buf.push_back(digit_char($urandom_range(b - 1)));
		if ($urandom_range(4) == 0) char_buf.push_back(8'($urandom_range(255)));
		else char_buf.push_back(CH_NUL);
	endtask

	task automatic test_auto_base();
		write_radix(BASE_AUTO);
		send_text(" \t\n-0x1aF", 1);
		send_text("0777", 1);
		send_text("0", 1);
		send_text("0x", 1);
		send_text("+", 1);
		send_text("", 1);
		send_text("-9223372036854775808", 1);
		send_text("18446744073709551615", 1);
		send_text("z", 1);
		// vertical tab is not leading space: it stops the parse
		send_text("  ", 0);
		send_char(CH_VT, 1'b0);
	endtask

	task automatic test_fixed_bases();
		write_radix(BASE_HEX);
		send_text("0Xff", 1);
		send_text("-0g", 1);
		write_radix(6'd1);
		send_text("0001", 1);
		write_radix(6'd36);
		send_text("zZ9!", 0);
		write_radix(BASE_DEC);
		send_text("0x12", 1);
		write_radix(BASE_OCT);
		send_text("789", 1);
		write_radix(6'd2);
		send_text("1012", 1);
	endtask

	task automatic test_idle_and_restart();
		write_radix(BASE_AUTO);
		// items while idle are ignored
		send_char("5", 1'b0);
		send_char(8'hFF, 1'b0);
		// a new start abandons the open string
		send_text("12", 0);
		send_text("-34", 1);
		// trailing items after the stop are ignored
		send_char("9", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_text("7", 1);
	endtask

	task automatic test_random_strings();
		logic [5:0] radix_plan[9];
		int unsigned sent;
		int unsigned pick;
		radix_plan = '{BASE_AUTO, 6'd36, BASE_HEX, BASE_DEC, 6'd1,
			BASE_AUTO, BASE_OCT, 6'd2, 6'd35};
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: set_idling(36, 45);
				1: set_idling(45, 36);
				default: set_idling(0, 0);
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				write_radix(radix_plan[mode * 3 + seg]);
				sent = 0;
				while (sent < 65) begin
					pick = $urandom_range(9);
					if (pick == 0) begin
						// noise: random bytes with random starts
						repeat ($urandom_range(1, 4))
							send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
					end else begin
						build_random_string();
						// broken string: leave it open for the next start
						if (pick == 1) void'(char_buf.pop_back());
						send_buf();
						sent += char_buf.size();
					end
				end
			end
		end
	endtask

	task automatic test_backpressure();
		write_radix(BASE_AUTO);
		set_idling(0, 0);
		hold_req = 80;
		repeat (12) begin
			build_random_string();
			send_buf();
		end
		wait_drained();
	endtask

	// Stall the result channel: long hold-off on request, random otherwise
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_result
		parse_result_t due;
		if (arst_n && res_valid && !res_stall) begin
			if (results_due.size() == 0) begin
				$error("result with no parse pending: value %0d consumed %0d", value, consumed);
				fail_count++;
			end else begin
				due = results_due.pop_front();
				if (value !== due.value) begin
					$error("value: expected %0d, actual %0d", due.value, value);
					fail_count++;
				end
				if (consumed !== due.consumed) begin
					$error("consumed: expected %0d, actual %0d", due.consumed, consumed);
					fail_count++;
				end
			end
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (res_valid && !res_stall)) begin
				idle_run = 0;
			end else begin
				idle_run++;
				if (idle_run >= WATCHDOG_LIMIT) begin
					$display("testbench NOT OK");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_idling(36, 45);
		test_auto_base();
		test_fixed_bases();
		test_idle_and_restart();
		test_random_strings();
		test_backpressure();
		if (pr_phase != PH_IDLE) send_char(CH_NUL, 1'b0);
		wait_drained();
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/strint_pkg.sv
rtl/core/strint_front.sv
rtl/core/strint_fifo.sv
rtl/core/strint_back.sv
rtl/core/string_to_integer_parser_unit.sv
test/testbench.sv
